/* design/nce_pkg.sv */
// ----------------------------------------------------------------------------
// nce_pkg: shared types and constants of the nonzero coordinate emitter
// Holds the field widths, the register map, the element kind codes and the
// normalized configuration that is passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nce_pkg;

  localparam int MAX_DIMS      = 4;
  localparam int DIM_BITS      = 2;
  localparam int COORD_BITS    = 16;
  localparam int INDEX_BITS    = 32;
  localparam int VALUE_BITS    = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS + 1;
  localparam int DCNT_BITS     = 3;
  localparam int KIND_BITS     = 2;

  // Largest float64 magnitude (as bits) that still rounds to zero in float32.
  localparam logic [VALUE_BITS-2:0] F64_HALF_MIN_SUB = 63'h3690000000000000;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INT = 2'd0,
    KIND_F32 = 2'd1,
    KIND_F64 = 2'd2
  } elem_kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE_DIM0 = 3'd1,
    REG_SIZE_DIM1 = 3'd2,
    REG_SIZE_DIM2 = 3'd3,
    REG_SIZE_DIM3 = 3'd4,
    REG_ELEM_KIND = 3'd5
  } cfg_reg_e;

  typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_vec_t;

  // Configuration after clamping: last dimension index in use, extents minus
  // one, and the raw element kind code.
  typedef struct packed {
    logic [DIM_BITS-1:0]  dims_m1;
    coord_vec_t           ext_m1;
    logic [KIND_BITS-1:0] kind;
  } cfg_t;

endpackage

`default_nettype wire

/* design/nonzero_coordinate_emitter.sv */
// ----------------------------------------------------------------------------
// nonzero_coordinate_emitter: stream of nonzero element coordinates
// Takes tensor elements in row-major order and emits coordinates, flat index
// and running count for every nonzero element and for the last element.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one element per beat (in_valid_i / in_stall_o);
// last_element_i marks the final element of a tensor. The output channel
// (out_valid_o / out_stall_i) carries one result beat per nonzero element,
// plus one for the last element, flagged with end_of_tensor_o.
// A beat accepted from the input channel sits in the input register, where it
// is tested and counted, and its result is then held in the output register.
// One element is taken in every cycle while the receiver keeps up; the rate
// is set by the single input-to-result register stage.
// When the receiver stalls with a result waiting, the element already in the
// input register stays there and in_stall_o rises until the output register
// frees up. Reset clears the configuration to one dimension of extent one
// with integer elements, clears all counters and empties both registers.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// should only change while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module nonzero_coordinate_emitter
  import nce_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [VALUE_BITS-1:0]    element_value_i,
  input  wire logic                     last_element_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          is_nonzero_o,
  output logic [COORD_BITS-1:0]         coord_0_o,
  output logic [COORD_BITS-1:0]         coord_1_o,
  output logic [COORD_BITS-1:0]         coord_2_o,
  output logic [COORD_BITS-1:0]         coord_3_o,
  output logic [INDEX_BITS-1:0]         flat_position_o,
  output logic [INDEX_BITS-1:0]         hits_so_far_o,
  output logic                          end_of_tensor_o
);

  cfg_t                  cfg;

  // Input register.
  logic                  s1_valid_q, s1_valid_d;
  logic [VALUE_BITS-1:0] s1_value_q;
  logic                  s1_last_q;

  // Handshake control.
  logic                  in_acc;
  logic                  out_free;
  logic                  s1_adv;
  logic                  emit;

  // Combinational results of the single stage.
  logic                  nonzero;
  coord_vec_t            coord;
  logic [INDEX_BITS-1:0] position;
  logic [INDEX_BITS-1:0] hits;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic                  nz_q;
  coord_vec_t            coord_q;
  logic [INDEX_BITS-1:0] pos_q;
  logic [INDEX_BITS-1:0] hits_q;
  logic                  eot_q;

  nce_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nce_zero_detect u_zero_detect (
    .value_i   (s1_value_q),
    .kind_i    (cfg.kind),
    .nonzero_o (nonzero)
  );

  nce_coord_counter u_coord_counter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (s1_adv),
    .nonzero_i  (nonzero),
    .last_i     (s1_last_q),
    .coord_o    (coord),
    .position_o (position),
    .hits_o     (hits)
  );

  // The element in the input register moves on whenever the output register
  // is empty or is being drained in this cycle, whether it emits or not.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit       = nonzero || s1_last_q;

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv ? emit : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_value_q <= element_value_i;
      s1_last_q  <= last_element_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      nz_q    <= nonzero;
      coord_q <= coord;
      pos_q   <= position;
      hits_q  <= hits;
      eot_q   <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_nonzero_o    = nz_q;
  assign coord_0_o       = coord_q[0];
  assign coord_1_o       = coord_q[1];
  assign coord_2_o       = coord_q[2];
  assign coord_3_o       = coord_q[3];
  assign flat_position_o = pos_q;
  assign hits_so_far_o   = hits_q;
  assign end_of_tensor_o = eot_q;

endmodule

`default_nettype wire

/* design/nce_cfg_regs.sv */
// ----------------------------------------------------------------------------
// nce_cfg_regs: configuration register file
// Takes register writes and keeps them in normalized form: the dimension
// count and the extents are clamped to their supported ranges on write.
// ----------------------------------------------------------------------------
`default_nettype none

module nce_cfg_regs
  import nce_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output cfg_t                          cfg_o
);

  localparam logic [CFG_DATA_BITS-1:0] EXT_LIMIT = CFG_DATA_BITS'(1) << COORD_BITS;

  cfg_t                  cfg_q, cfg_d;
  logic [DCNT_BITS-1:0]  dcnt;
  logic [DIM_BITS-1:0]   dims_m1;
  logic [COORD_BITS-1:0] ext_m1;

  always_comb begin
    dcnt = cfg_wdata_i[DCNT_BITS-1:0];
    if (dcnt == '0) begin
      dims_m1 = '0;
    end else if (dcnt > DCNT_BITS'(MAX_DIMS)) begin
      dims_m1 = DIM_BITS'(MAX_DIMS - 1);
    end else begin
      dims_m1 = DIM_BITS'(dcnt - DCNT_BITS'(1));
    end

    if (cfg_wdata_i == '0) begin
      ext_m1 = '0;
    end else if (cfg_wdata_i > EXT_LIMIT) begin
      ext_m1 = '1;
    end else begin
      ext_m1 = COORD_BITS'(cfg_wdata_i - CFG_DATA_BITS'(1));
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIM_COUNT: cfg_d.dims_m1   = dims_m1;
        REG_SIZE_DIM0: cfg_d.ext_m1[0] = ext_m1;
        REG_SIZE_DIM1: cfg_d.ext_m1[1] = ext_m1;
        REG_SIZE_DIM2: cfg_d.ext_m1[2] = ext_m1;
        REG_SIZE_DIM3: cfg_d.ext_m1[3] = ext_m1;
        REG_ELEM_KIND: cfg_d.kind      = cfg_wdata_i[KIND_BITS-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dims_m1 <= '0;
      cfg_q.ext_m1  <= '0;
      cfg_q.kind    <= KIND_INT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/nce_zero_detect.sv */
// ----------------------------------------------------------------------------
// nce_zero_detect: element zero test
// Decides whether an element is nonzero for the configured element kind.
// ----------------------------------------------------------------------------
`default_nettype none

module nce_zero_detect
  import nce_pkg::*;
(
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic [KIND_BITS-1:0]  kind_i,
  output logic                       nonzero_o
);

  always_comb begin
    case (kind_i)
      // Float32: both signed zeros count as zero.
      KIND_F32: nonzero_o = (value_i[30:0] != '0);
      // Float64: nonzero only if it survives conversion to float32.
      KIND_F64: nonzero_o = (value_i[VALUE_BITS-2:0] > F64_HALF_MIN_SUB);
      default:  nonzero_o = (value_i != '0);
    endcase
  end

endmodule

`default_nettype wire

/* design/nce_coord_counter.sv */
// ----------------------------------------------------------------------------
// nce_coord_counter: mixed-radix coordinate, position and hit counters
// Holds the coordinates of the element in flight, its flat position and the
// running nonzero count; steps them once per element, clearing after the last.
// ----------------------------------------------------------------------------
`default_nettype none

module nce_coord_counter
  import nce_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  step_i,
  input  wire logic                  nonzero_i,
  input  wire logic                  last_i,
  output coord_vec_t                 coord_o,
  output logic [INDEX_BITS-1:0]      position_o,
  output logic [INDEX_BITS-1:0]      hits_o
);

  coord_vec_t              coord_q, coord_d;
  logic [INDEX_BITS-1:0]   pos_q, pos_d;
  logic [INDEX_BITS-1:0]   hit_q, hit_d;
  logic [INDEX_BITS-1:0]   hits;
  logic [MAX_DIMS-1:0]     in_use;
  coord_vec_t              coord_adv;
  logic                    carry;
  logic                    wrap;

  // The last dimension in use is the fastest; a carry moves toward dim 0.
  always_comb begin
    carry     = 1'b1;
    coord_adv = coord_q;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      in_use[d] = (DIM_BITS'(d) <= cfg_i.dims_m1);
      wrap      = (coord_q[d] >= cfg_i.ext_m1[d]);
      if (in_use[d]) begin
        if (carry) begin
          coord_adv[d] = wrap ? '0 : coord_q[d] + COORD_BITS'(1);
        end
        carry = carry & wrap;
      end
    end
  end

  assign hits = nonzero_i ? hit_q + INDEX_BITS'(1) : hit_q;

  always_comb begin
    coord_d = coord_q;
    pos_d   = pos_q;
    hit_d   = hit_q;
    if (step_i) begin
      if (last_i) begin
        coord_d = '0;
        pos_d   = '0;
        hit_d   = '0;
      end else begin
        coord_d = coord_adv;
        pos_d   = pos_q + INDEX_BITS'(1);
        hit_d   = hits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      pos_q   <= '0;
      hit_q   <= '0;
    end else begin
      coord_q <= coord_d;
      pos_q   <= pos_d;
      hit_q   <= hit_d;
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      coord_o[d] = in_use[d] ? coord_q[d] : '0;
    end
  end

  assign position_o = pos_q;
  assign hits_o     = hits;

endmodule

`default_nettype wire
